[hdl/bhe_pkg.sv]
// Shared sizes and request codes for the byte histogram engine.
package bhe_pkg;

  // Number of bins and width of each bin counter.
  localparam int unsigned BIN_COUNT   = 256;
  localparam int unsigned COUNT_WIDTH = 32;

  // A byte reaches at most 256 bins; higher bins never count and read as zero.
  localparam int unsigned BYTE_BINS   = 256;
  localparam int unsigned LIVE_BINS   = (BIN_COUNT < BYTE_BINS) ? BIN_COUNT : BYTE_BINS;
  localparam int unsigned ADDR_W      = $clog2(LIVE_BINS);

  // Field widths of the stream payloads.
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned OUT_CNT_W   = 32;
  localparam int unsigned S_DATA_W    = 2 * IDX_W;
  localparam int unsigned M_DATA_W    = IDX_W + OUT_CNT_W;

  // Request codes carried in the slave tuser.
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

endpackage

[hdl/byte_histogram_engine_core.sv]
// Byte histogram engine: counter table in a synchronous RAM with read-modify-write.
//
// The block keeps one counter per bin and serves three kinds of request, chosen
// by s_axis_tuser_i: count a sample byte (its bin goes up by one, wrapping at
// 2^COUNT_WIDTH; a byte at or above the bin count is dropped), read one bin
// (one output transaction carrying the bin index and its count; a bin that does
// not exist reads zero), and clear all bins. Only read requests produce output.
// The table lives in a RAM with a registered read. A request enters the read
// stage when accepted, then modifies and writes back from the modify stage;
// a one-entry bypass register forwards the last write so that back-to-back
// samples of the same byte count correctly. The block accepts one transaction
// every cycle; only a read whose result finds the output register still
// occupied and not taken holds the input while the downstream stalls. Clear
// and reset act through per-bin valid flops and finish at once: there is no
// clearing pass, and a request may follow a clear in the next cycle.
module byte_histogram_engine_core
  import bhe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,   // [7:0] sample_value, [15:8] read_bin
  input  logic [REQ_W-1:0]    s_axis_tuser_i,   // [1:0] req_type
  // Result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o    // [7:0] bin_index, [39:8] bin_count
);

  // Counter RAM, one entry per reachable bin.
  logic [COUNT_WIDTH-1:0] mem_q [LIVE_BINS];
  logic [COUNT_WIDTH-1:0] rd_q;

  // Per-bin valid flops: a bin not written since reset or clear reads zero.
  logic [LIVE_BINS-1:0]   vld_q, vld_d;

  // Modify stage.
  logic                   s1_vld_q, s1_vld_d;
  logic [REQ_W-1:0]       s1_type_q;
  logic [IDX_W-1:0]       s1_idx_q;
  logic                   s1_ok_q;

  // Bypass of the most recent write.
  logic                   fwd_vld_q, fwd_vld_d;
  logic [ADDR_W-1:0]      fwd_addr_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;

  // Output register.
  logic                   out_vld_q, out_vld_d;
  logic [IDX_W-1:0]       out_idx_q;
  logic [OUT_CNT_W-1:0]   out_cnt_q;

  logic                   in_fire;
  logic [IDX_W-1:0]       in_sample, in_read_bin, in_idx;
  logic                   in_ok;
  logic                   s1_go;
  logic [ADDR_W-1:0]      s1_addr;
  logic [COUNT_WIDTH-1:0] s1_val;
  logic                   wr_en;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   rd_out;
  logic [63:0]            val_wide;

  assign in_sample   = s_axis_tdata_i[IDX_W-1:0];
  assign in_read_bin = s_axis_tdata_i[2*IDX_W-1:IDX_W];
  assign in_idx      = (s_axis_tuser_i == REQ_READ) ? in_read_bin : in_sample;
  assign in_ok       = ({1'b0, in_idx} < 9'(LIVE_BINS));

  // Hold the modify stage only while a read result cannot be parked.
  assign s1_go           = !(s1_type_q == REQ_READ) || !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_vld_q || s1_go;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign s1_addr = s1_idx_q[ADDR_W-1:0];

  // Current bin value: bypass first, then RAM data if the bin is live.
  always_comb begin
    if (fwd_vld_q && (fwd_addr_q == s1_addr)) begin
      s1_val = fwd_data_q;
    end else if (vld_q[s1_addr]) begin
      s1_val = rd_q;
    end else begin
      s1_val = '0;
    end
  end

  assign wr_data  = s1_val + COUNT_WIDTH'(1);
  assign val_wide = s1_ok_q ? 64'(s1_val) : 64'd0;

  always_comb begin
    wr_en     = 1'b0;
    rd_out    = 1'b0;
    vld_d     = vld_q;
    fwd_vld_d = fwd_vld_q;
    if (s1_vld_q && s1_go) begin
      case (s1_type_q)
        REQ_SAMPLE: begin
          if (s1_ok_q) begin
            wr_en          = 1'b1;
            vld_d[s1_addr] = 1'b1;
            fwd_vld_d      = 1'b1;
          end
        end
        REQ_READ: begin
          rd_out = 1'b1;
        end
        REQ_CLEAR: begin
          // Drop every bin and the bypass at once.
          vld_d     = '0;
          fwd_vld_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) begin
      s1_vld_d = 1'b1;
    end else if (s1_go) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (rd_out) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // RAM: read at accept, write back from the modify stage.
  always_ff @(posedge clk_i) begin
    if (in_fire && in_ok) begin
      rd_q <= mem_q[in_idx[ADDR_W-1:0]];
    end
    if (wr_en) begin
      mem_q[s1_addr] <= wr_data;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_type_q <= s_axis_tuser_i;
      s1_idx_q  <= in_idx;
      s1_ok_q   <= in_ok;
    end
    if (wr_en) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= wr_data;
    end
    if (rd_out) begin
      out_idx_q <= s1_idx_q;
      out_cnt_q <= val_wide[OUT_CNT_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      s1_vld_q  <= s1_vld_d;
      fwd_vld_q <= fwd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_idx_q};

endmodule
